// File: src/rc_frame_crc_channel_decoder_assert.svh
// Assertion macros shared by the frame decoder modules
`ifndef RC_FRAME_CRC_CHANNEL_DECODER_ASSERT_SVH
`define RC_FRAME_CRC_CHANNEL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCFCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcfcd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RCFCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcfcd assertion failed");

`endif

// File: src/rcfcd_pkg.sv
// Types, constants and CRC step function for the radio-control frame decoder
package rcfcd_pkg;

    localparam logic [3:0]  FRAME_LEN    = 4'd11;
    localparam logic [3:0]  LAST_POS     = 4'd10;
    localparam logic [3:0]  CRC_FIRST    = 4'd3;
    localparam int          STORE_DEPTH  = 10;
    localparam logic [15:0] CRC_POLY     = 16'h8005;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  LOST_MASK    = 8'hC0;
    localparam logic [7:0]  LOST_MARK    = 8'h40;
    localparam logic [11:0] STICK_CENTER = 12'd1020;
    localparam logic [11:0] THROTTLE_BASE = 12'd210;
    localparam logic [11:0] THROTTLE_MAX = 12'd1640;
    localparam logic [7:0]  COUNT_MAX    = 8'd255;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic               crc_ok;
        logic               packet_lost;
        logic signed [11:0] stick_roll;
        logic signed [11:0] stick_pitch;
        logic signed [11:0] stick_yaw;
        logic [10:0]        throttle_level;
        logic [11:0]        aux_bits;
        logic [7:0]         rssi_byte;
        logic               link_ready;
        logic               bind_mode;
    } t_result;

    typedef struct packed {
        logic               fire;
        t_byte [10:0]       frame;
        logic [15:0]        crc;
    } t_frame_done;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        top;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            top = c[15] ^ b[7-k];
            c   = {c[14:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: src/rcfcd_frame_asm.sv
// Input register, byte position tracking, frame store and running CRC
`include "rc_frame_crc_channel_decoder_assert.svh"

module rcfcd_frame_asm (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rcfcd_pkg::t_in_item    i_item,
    output logic                   o_stall,
    input  logic                   i_adv_ok,
    output rcfcd_pkg::t_frame_done o_done
);

    logic                r_in_valid;
    rcfcd_pkg::t_in_item r_in;
    logic [3:0]          r_pos;
    logic [15:0]         r_crc;
    rcfcd_pkg::t_byte    r_store [rcfcd_pkg::STORE_DEPTH];

    logic        active;
    logic        last;
    logic        adv;
    logic [3:0]  pos;
    logic [3:0]  n_pos;
    logic [15:0] crc_base;
    logic [15:0] n_crc;

    always_comb begin
        pos      = r_in.frame_start ? 4'd0 : r_pos;
        active   = r_in.frame_start || (r_pos < rcfcd_pkg::FRAME_LEN);
        last     = active && (pos == rcfcd_pkg::LAST_POS);
        adv      = r_in_valid && (!last || i_adv_ok);
        crc_base = r_in.frame_start ? rcfcd_pkg::CRC_INIT : r_crc;
        n_crc    = (pos >= rcfcd_pkg::CRC_FIRST) ?
                   rcfcd_pkg::crc_byte(crc_base, r_in.frame_byte) : crc_base;
        n_pos    = pos + 4'd1;
    end

    assign o_stall = r_in_valid && !adv;

    always_comb begin
        o_done.fire = adv && last;
        o_done.crc  = n_crc;
        for (int k = 0; k < rcfcd_pkg::STORE_DEPTH; k++) begin
            o_done.frame[k] = r_store[k];
        end
        o_done.frame[10] = r_in.frame_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= rcfcd_pkg::FRAME_LEN;
            r_crc      <= rcfcd_pkg::CRC_INIT;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv && active) begin
                r_pos <= n_pos;
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
        for (int k = 0; k < rcfcd_pkg::STORE_DEPTH; k++) begin
            if (adv && active && (pos == 4'(k))) begin
                r_store[k] <= r_in.frame_byte;
            end
        end
    end

    `RCFCD_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= rcfcd_pkg::FRAME_LEN)
    `RCFCD_ASSERT_IMP(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_in_valid)
    `RCFCD_ASSERT_NEXT(a_fire_closes_frame, i_clk, i_rst_n, o_done.fire,
        r_pos == rcfcd_pkg::FRAME_LEN)

endmodule

// File: src/rcfcd_result.sv
// CRC compare, channel unpack, link flags and result register
`include "rc_frame_crc_channel_decoder_assert.svh"

module rcfcd_result #(
    parameter int BIND_GOOD_FRAMES = 130
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rcfcd_pkg::t_frame_done i_done,
    output logic                   o_adv_ok,
    output logic                   o_valid,
    input  logic                   i_stall,
    output rcfcd_pkg::t_result     o_item
);

    localparam logic [7:0] BIND_LIM  = 8'(BIND_GOOD_FRAMES);
    localparam logic [7:0] READY_LIM = 8'(BIND_GOOD_FRAMES + 1);

    logic               r_out_valid;
    rcfcd_pkg::t_result r_out;
    logic [7:0]         r_cnt;
    logic               r_ready;
    logic               r_bind;

    rcfcd_pkg::t_result n_out;
    logic [7:0]         n_cnt;
    logic               n_ready;
    logic               n_bind;
    logic               ok;
    logic               lost;
    logic [10:0]        c0;
    logic [10:0]        c1;
    logic [10:0]        c2;
    logic [10:0]        c3;
    logic [11:0]        thr;

    always_comb begin
        ok   = i_done.crc == {i_done.frame[1], i_done.frame[2]};
        lost = (i_done.frame[0] & rcfcd_pkg::LOST_MASK) == rcfcd_pkg::LOST_MARK;
        c0   = {i_done.frame[4][2:0], i_done.frame[3]};
        c1   = {i_done.frame[5][6:0], i_done.frame[4][7:4]};
        c2   = {i_done.frame[7][2:0], i_done.frame[6]};
        c3   = {i_done.frame[8][6:0], i_done.frame[7][7:4]};
        thr  = {1'b0, c2} - rcfcd_pkg::THROTTLE_BASE;
        if (thr[11]) begin
            thr = '0;
        end else if (thr > rcfcd_pkg::THROTTLE_MAX) begin
            thr = rcfcd_pkg::THROTTLE_MAX;
        end

        n_cnt   = r_cnt;
        n_ready = r_ready;
        n_bind  = r_bind;
        n_out   = '0;
        if (ok) begin
            n_out.crc_ok      = 1'b1;
            n_out.packet_lost = lost;
            if (!lost) begin
                n_out.stick_roll     = $signed({1'b0, c0} - rcfcd_pkg::STICK_CENTER);
                n_out.stick_pitch    = $signed({1'b0, c1} - rcfcd_pkg::STICK_CENTER);
                n_out.stick_yaw      = $signed({1'b0, c3} - rcfcd_pkg::STICK_CENTER);
                n_out.throttle_level = thr[10:0];
                n_out.aux_bits       = {i_done.frame[9], i_done.frame[8][7],
                                        i_done.frame[7][3], i_done.frame[5][7],
                                        i_done.frame[4][3]};
                n_out.rssi_byte      = i_done.frame[10];
                if (r_cnt != rcfcd_pkg::COUNT_MAX) begin
                    n_cnt = r_cnt + 8'd1;
                end
                if (n_cnt < BIND_LIM) begin
                    n_bind = 1'b1;
                end
            end
            if (n_cnt > READY_LIM) begin
                n_ready = 1'b1;
                n_bind  = 1'b0;
                n_cnt   = READY_LIM;
            end
        end
        n_out.link_ready = n_ready;
        n_out.bind_mode  = n_bind;
    end

    assign o_adv_ok = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ready     <= 1'b0;
            r_bind      <= 1'b0;
        end else begin
            if (i_done.fire) begin
                r_out_valid <= 1'b1;
                r_cnt       <= n_cnt;
                r_ready     <= n_ready;
                r_bind      <= n_bind;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_done.fire) begin
            r_out <= n_out;
        end
    end

    `RCFCD_ASSERT_IMP(a_ready_ends_bind, i_clk, i_rst_n, r_ready, !r_bind)
    `RCFCD_ASSERT_IMP(a_ready_count, i_clk, i_rst_n, r_ready, r_cnt == READY_LIM)
    `RCFCD_ASSERT_IMP(a_bad_crc_zero, i_clk, i_rst_n, r_out_valid && !r_out.crc_ok,
        !r_out.packet_lost && (r_out.rssi_byte == 8'd0) && (r_out.aux_bits == 12'd0))

endmodule

// File: src/rc_frame_crc_channel_decoder.sv
// A frame result is valid in the cycle after the transfer of its last byte.
// One byte per cycle when not stalled; input register advances into result register.
// A frame result waits in the result register while the next bytes keep arriving;
// only the last byte of the next frame stalls until that result is transferred.
// Reset (synchronous, active low) empties both registers, waits for a start byte,
// and clears the good-frame count and the ready and bind flags.
module rc_frame_crc_channel_decoder #(
    parameter int BIND_GOOD_FRAMES = 130
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rcfcd_pkg::t_in_item i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output rcfcd_pkg::t_result  o_item
);

    rcfcd_pkg::t_frame_done done;
    logic                   adv_ok;

    rcfcd_frame_asm u_frame_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_stall  (o_stall),
        .i_adv_ok (adv_ok),
        .o_done   (done)
    );

    rcfcd_result #(
        .BIND_GOOD_FRAMES (BIND_GOOD_FRAMES)
    ) u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_done   (done),
        .o_adv_ok (adv_ok),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item)
    );

endmodule
